### hw/rtl/orc_pkg.sv
// orc_pkg: shared types and constants for the occupancy ray update core
// used by orc_ctrl, orc_walker, orc_grid and occupancy_ray_update_core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package orc_pkg;

   localparam int COORD_W = 12;
   localparam int CELL_W  = 12;
   localparam int CNT_W   = 13;
   localparam int ERR_W   = 15;
   localparam int SIZE_W  = 10;
   localparam int STEP_W  = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] REG_FREE_STEP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OCC_STEP   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CLAMP_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CLAMP_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_HEIGHT = 3'd5;

   localparam logic [CELL_W-1:0]  FREE_STEP_RST  = 12'hF9A;  // -102
   localparam logic [STEP_W-1:0]  OCC_STEP_RST   = 11'd218;
   localparam logic [CELL_W-1:0]  CLAMP_LOW_RST  = 12'hB00;  // -1280
   localparam logic [STEP_W-1:0]  CLAMP_HIGH_RST = 11'd1280;
   localparam logic [SIZE_W-1:0]  MAP_SIZE_RST   = 10'd400;

   localparam logic REQ_RAY = 1'b0;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [CELL_W-1:0]  cell_type;

   typedef struct packed {
      logic clear_en;
      logic load;
      logic walk_step;
      logic hit_step;
      logic read_cell;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_read;
      logic mark_hit;
      logic at_end;
      logic rsp_full;
   } sts_type;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_START = 6'b000100,
      ST_WALK  = 6'b001000,
      ST_HIT   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/orc_ctrl.sv
// orc_ctrl: sequencing state machine for clear, ray walk, hit and read requests
// depends on orc_pkg
`timescale 1ns / 1ps
`default_nettype none

module orc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  orc_pkg::sts_type sts,
   output orc_pkg::cmd_type cmd
);
   import orc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (sts.is_read) begin
               cmd.read_cell = 1'b1;
               state_in      = ST_DONE;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (sts.at_end) begin
               state_in = sts.mark_hit ? ST_HIT : ST_DONE;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         ST_HIT: begin
            cmd.hit_step = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (!sts.rsp_full) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/orc_walker.sv
// orc_walker: bresenham line stepper with grid bounds check and cell address
// keeps the request fields, updated-cell count and hit flag; depends on orc_pkg
`timescale 1ns / 1ps
`default_nettype none

module orc_walker #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512,
   parameter int AW         = 18
) (
   input  logic                             clock,
   input  logic                             reset,
   input  orc_pkg::cmd_type                 cmd,
   input  logic                             req_type,
   input  orc_pkg::coord_type               start_x,
   input  orc_pkg::coord_type               start_y,
   input  orc_pkg::coord_type               end_x,
   input  orc_pkg::coord_type               end_y,
   input  logic                             mark_hit,
   input  logic [orc_pkg::SIZE_W-1:0]       map_width,
   input  logic [orc_pkg::SIZE_W-1:0]       map_height,
   output logic                             cell_inside,
   output logic [AW-1:0]                    cell_addr,
   output logic                             at_end,
   output logic                             is_read,
   output logic                             hit_mark,
   output logic [orc_pkg::CNT_W-1:0]        cells_changed,
   output logic                             hit_applied
);
   import orc_pkg::*;

   localparam logic [AW-1:0] ROW_PITCH = AW'(MAX_WIDTH);

   coord_type x_ff, x_in, y_ff, y_in, x1_ff, x1_in, y1_ff, y1_in;
   logic [COORD_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic sx_neg_ff, sx_neg_in, sy_neg_ff, sy_neg_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic hit_ff, hit_in, read_ff, read_in, mark_ff, mark_in;

   logic signed [COORD_W:0] diff_x, diff_y;
   logic [COORD_W-1:0] abs_x, abs_y;
   logic signed [ERR_W:0] e2, neg_dy, pos_dx;
   logic move_x, move_y;
   logic [SIZE_W-1:0] used_w, used_h;
   logic [AW-1:0] x_a, y_a;

   // bounds of the grid in use
   always_comb begin
      used_w = ({3'b000, map_width} > 13'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : map_width;
      used_h = ({3'b000, map_height} > 13'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : map_height;
      cell_inside = !x_ff[COORD_W-1] && !y_ff[COORD_W-1]
                    && (x_ff[COORD_W-2:0] < {1'b0, used_w})
                    && (y_ff[COORD_W-2:0] < {1'b0, used_h});
      x_a       = AW'(x_ff[COORD_W-2:0]);
      y_a       = AW'(y_ff[COORD_W-2:0]);
      cell_addr = AW'(y_a * ROW_PITCH + x_a);
      at_end    = (x_ff == x1_ff) && (y_ff == y1_ff);
   end

   // line setup and step
   always_comb begin
      diff_x = {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
      diff_y = {end_y[COORD_W-1], end_y} - {start_y[COORD_W-1], start_y};
      abs_x  = diff_x[COORD_W] ? COORD_W'(-diff_x) : diff_x[COORD_W-1:0];
      abs_y  = diff_y[COORD_W] ? COORD_W'(-diff_y) : diff_y[COORD_W-1:0];

      e2     = {err_ff, 1'b0};
      pos_dx = {4'b0000, dx_ff};
      neg_dy = -$signed({4'b0000, dy_ff});
      move_x = e2 > neg_dy;
      move_y = e2 < pos_dx;

      x_in      = x_ff;
      y_in      = y_ff;
      x1_in     = x1_ff;
      y1_in     = y1_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      sx_neg_in = sx_neg_ff;
      sy_neg_in = sy_neg_ff;
      err_in    = err_ff;
      cnt_in    = cnt_ff;
      hit_in    = hit_ff;
      read_in   = read_ff;
      mark_in   = mark_ff;

      if (cmd.load) begin
         x_in      = start_x;
         y_in      = start_y;
         x1_in     = end_x;
         y1_in     = end_y;
         dx_in     = abs_x;
         dy_in     = abs_y;
         sx_neg_in = !(start_x < end_x);
         sy_neg_in = !(start_y < end_y);
         err_in    = $signed({3'b000, abs_x}) - $signed({3'b000, abs_y});
         cnt_in    = '0;
         hit_in    = 1'b0;
         read_in   = (req_type != REQ_RAY);
         mark_in   = mark_hit;
      end else if (cmd.walk_step) begin
         if (move_x) begin
            x_in = sx_neg_ff ? x_ff - 12'sd1 : x_ff + 12'sd1;
         end
         if (move_y) begin
            y_in = sy_neg_ff ? y_ff - 12'sd1 : y_ff + 12'sd1;
         end
         err_in = err_ff - (move_x ? $signed({3'b000, dy_ff}) : '0)
                         + (move_y ? $signed({3'b000, dx_ff}) : '0);
         cnt_in = cnt_ff + CNT_W'(cell_inside);
      end else if (cmd.hit_step) begin
         hit_in = cell_inside;
         cnt_in = cnt_ff + CNT_W'(cell_inside);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         hit_ff  <= 1'b0;
         read_ff <= 1'b0;
         mark_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         hit_ff  <= hit_in;
         read_ff <= read_in;
         mark_ff <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      x1_ff     <= x1_in;
      y1_ff     <= y1_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      sx_neg_ff <= sx_neg_in;
      sy_neg_ff <= sy_neg_in;
      err_ff    <= err_in;
   end

   assign is_read       = read_ff;
   assign hit_mark      = mark_ff;
   assign cells_changed = cnt_ff;
   assign hit_applied   = hit_ff;

endmodule

`default_nettype wire

### hw/rtl/orc_grid.sv
// orc_grid: log-odds cell memory with clearing pass and read-add-clamp-write pipeline
// one read and one write port, registered read data; depends on orc_pkg
`timescale 1ns / 1ps
`default_nettype none

module orc_grid #(
   parameter int DEPTH = 262144,
   parameter int AW    = 18
) (
   input  logic                         clock,
   input  logic                         reset,
   input  orc_pkg::cmd_type             cmd,
   input  logic                         cell_inside,
   input  logic [AW-1:0]                cell_addr,
   input  orc_pkg::cell_type            free_step,
   input  logic [orc_pkg::STEP_W-1:0]   occ_step,
   input  orc_pkg::cell_type            clamp_low,
   input  logic [orc_pkg::STEP_W-1:0]   clamp_high,
   output logic                         clear_last,
   output orc_pkg::cell_type            rd_data
);
   import orc_pkg::*;

   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   logic [CELL_W-1:0] grid_ff [DEPTH];

   logic [AW-1:0] clr_ff, clr_in;
   logic upd_b_ff, upd_b_in;
   logic hit_b_ff;
   logic [AW-1:0] addr_b_ff;
   cell_type rdata_ff;

   logic rd_en, wr_en;
   logic [AW-1:0] wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic signed [CELL_W+1:0] sum, step_x, lim_hi, lim_lo, sat_hi, sat;

   always_comb begin
      rd_en    = cell_inside & (cmd.walk_step | cmd.hit_step | cmd.read_cell);
      upd_b_in = cell_inside & (cmd.walk_step | cmd.hit_step);
      clr_in   = cmd.clear_en ? clr_ff + AW'(1) : clr_ff;

      step_x = hit_b_ff ? $signed({3'b000, occ_step})
                        : $signed({{2{free_step[CELL_W-1]}}, free_step});
      sum    = $signed({{2{rdata_ff[CELL_W-1]}}, rdata_ff}) + step_x;
      lim_hi = $signed({3'b000, clamp_high});
      lim_lo = $signed({{2{clamp_low[CELL_W-1]}}, clamp_low});
      sat_hi = (sum > lim_hi) ? lim_hi : sum;
      sat    = (sat_hi < lim_lo) ? lim_lo : sat_hi;

      wr_en   = cmd.clear_en | upd_b_ff;
      wr_addr = cmd.clear_en ? clr_ff : addr_b_ff;
      wr_data = cmd.clear_en ? '0 : sat[CELL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         upd_b_ff <= 1'b0;
      end else begin
         clr_ff   <= clr_in;
         upd_b_ff <= upd_b_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_b_ff  <= cmd.hit_step;
      addr_b_ff <= cell_addr;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= grid_ff[cell_addr];
      end
   end

   assign clear_last = (clr_ff == LAST_ADDR);
   assign rd_data    = rdata_ff;

endmodule

`default_nettype wire

### hw/rtl/occupancy_ray_update_core.sv
// occupancy_ray_update_core: log-odds occupancy grid with bresenham ray updates
// a read looks up its cell in the start state, a ray walks the line up to its end cell and
// takes the hit step if marked; the walk does one cell read-add-clamp-write per cycle
// one request at a time; the result is loaded in the done state, which waits while the response is held
// reset: synchronous, restores register defaults, then a clearing pass zeroes all
// MAX_WIDTH*MAX_HEIGHT grid cells before the first request is taken
`timescale 1ns / 1ps
`default_nettype none

module occupancy_ray_update_core #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [55:0]                        req_tdata,   // start_x, start_y, end_x, end_y, mark_hit
   input  logic                               req_tuser,   // req_type
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [31:0]                        rsp_tdata,   // cell_value, cells_changed, hit_applied, outside_grid
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [orc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [orc_pkg::CSR_DATA_W-1:0]     csr_data
);
   import orc_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   cell_type free_step_ff, clamp_low_ff;
   logic [STEP_W-1:0] occ_step_ff, clamp_high_ff;
   logic [SIZE_W-1:0] map_width_ff, map_height_ff;

   logic rsp_valid_ff, rsp_valid_in;
   cell_type value_ff, value_in;
   logic [CNT_W-1:0] changed_ff;
   logic hit_ff, outside_ff, outside_in;

   cmd_type cmd;
   sts_type sts;

   logic cell_inside, at_end, is_read, hit_mark, hit_applied, clear_last;
   logic [AW-1:0] cell_addr;
   logic [CNT_W-1:0] cells_changed;
   cell_type rd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         free_step_ff  <= FREE_STEP_RST;
         occ_step_ff   <= OCC_STEP_RST;
         clamp_low_ff  <= CLAMP_LOW_RST;
         clamp_high_ff <= CLAMP_HIGH_RST;
         map_width_ff  <= MAP_SIZE_RST;
         map_height_ff <= MAP_SIZE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_FREE_STEP:  free_step_ff  <= csr_data;
            REG_OCC_STEP:   occ_step_ff   <= csr_data[STEP_W-1:0];
            REG_CLAMP_LOW:  clamp_low_ff  <= csr_data;
            REG_CLAMP_HIGH: clamp_high_ff <= csr_data[STEP_W-1:0];
            REG_MAP_WIDTH:  map_width_ff  <= csr_data[SIZE_W-1:0];
            REG_MAP_HEIGHT: map_height_ff <= csr_data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      sts.clear_last = clear_last;
      sts.is_read    = is_read;
      sts.mark_hit   = hit_mark;
      sts.at_end     = at_end;
      sts.rsp_full   = rsp_valid_ff & !rsp_tready;
   end

   orc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   orc_walker #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .AW         (AW)
   ) u_walker (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_type      (req_tuser),
      .start_x       (req_tdata[11:0]),
      .start_y       (req_tdata[23:12]),
      .end_x         (req_tdata[35:24]),
      .end_y         (req_tdata[47:36]),
      .mark_hit      (req_tdata[48]),
      .map_width     (map_width_ff),
      .map_height    (map_height_ff),
      .cell_inside   (cell_inside),
      .cell_addr     (cell_addr),
      .at_end        (at_end),
      .is_read       (is_read),
      .hit_mark      (hit_mark),
      .cells_changed (cells_changed),
      .hit_applied   (hit_applied)
   );

   orc_grid #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_grid (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cell_inside (cell_inside),
      .cell_addr   (cell_addr),
      .free_step   (free_step_ff),
      .occ_step    (occ_step_ff),
      .clamp_low   (clamp_low_ff),
      .clamp_high  (clamp_high_ff),
      .clear_last  (clear_last),
      .rd_data     (rd_data)
   );

   // result register
   always_comb begin
      value_in   = (is_read && cell_inside) ? rd_data : '0;
      outside_in = is_read && !cell_inside;
      priority if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         value_ff   <= value_in;
         changed_ff <= cells_changed;
         hit_ff     <= hit_applied;
         outside_ff <= outside_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, outside_ff, hit_ff, changed_ff, value_ff};

endmodule

`default_nettype wire

### verif/testbench.sv
// testbench: self-checking bench for occupancy_ray_update_core, covering ray updates
// and cell reads against a behavioral log-odds grid model kept inside the bench
// depends on orc_pkg and the occupancy_ray_update_core rtl
`timescale 1ns / 1ps

module testbench;
   import orc_pkg::*;

   localparam int MAX_W       = 512;
   localparam int MAX_H       = 512;
   localparam int MAP_CELLS   = MAX_W * MAX_H;
   localparam int HOLD_CYCLES = 600;
   localparam int IDLE_HEAVY  = 88;
   localparam int IDLE_BOTH   = 25;
   localparam int SHOW_LIMIT  = 20;
   localparam logic REQ_READ  = ~REQ_RAY;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 3'd7;

   typedef struct packed {
      logic      req_kind;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
      logic      mark_hit;
   } ray_req_type;

   typedef struct packed {
      cell_type         cell_value;
      logic [CNT_W-1:0] cells_changed;
      logic             hit_applied;
      logic             outside_grid;
   } ray_rsp_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [55:0]           req_tdata  = '0;   // start_x, start_y, end_x, end_y, mark_hit
   logic                  req_tuser  = 1'b0; // req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;         // cell_value, cells_changed, hit_applied, outside_grid
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   occupancy_ray_update_core #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // grid model and its register copies
   cell_type occ_map [MAP_CELLS];
   int free_step_q, occ_step_q, clamp_lo_q, clamp_hi_q, width_q, height_q;

   ray_req_type pending_requests [$];
   ray_rsp_type due_results [$];
   ray_req_type req_on_bus;
   ray_rsp_type predicted, observed, wanted;

   int     send_idle_pct  = 0;
   int     recv_stall_pct = 0;
   logic   hold_arm       = 1'b0;
   logic   hold_spent     = 1'b0;
   int     hold_left      = 0;
   int     fail_count     = 0;
   int     rays_sent      = 0;
   int     reads_sent     = 0;
   int     cells_updated  = 0;
   int     hits_landed    = 0;
   int     reads_outside  = 0;
   int     settings_run   = 0;
   longint work_budget    = 0;
   longint cycle_count    = 0;

   function automatic int cols_in_use();
      return (width_q < MAX_W) ? width_q : MAX_W;
   endfunction

   function automatic int rows_in_use();
      return (height_q < MAX_H) ? height_q : MAX_H;
   endfunction

   function automatic bit in_map(int x, int y);
      return x >= 0 && x < cols_in_use() && y >= 0 && y < rows_in_use();
   endfunction

   function automatic bit bump_cell(int x, int y, int step);
      int sum;
      if (!in_map(x, y))
         return 1'b0;
      sum = occ_map[y * MAX_W + x] + step;
      if (sum > clamp_hi_q)
         sum = clamp_hi_q;
      if (sum < clamp_lo_q)
         sum = clamp_lo_q;
      occ_map[y * MAX_W + x] = CELL_W'(sum);
      return 1'b1;
   endfunction

   // reads return the cell; rays stop the bresenham walk before the end cell, then apply any hit
   function automatic ray_rsp_type update_grid(ray_req_type rq);
      ray_rsp_type rs;
      int x0, y0, x1, y1, dx, dy, sx, sy, err, e2, x, y, changed;
      bit landed;
      rs = '0;
      x0 = $signed(rq.start_x);
      y0 = $signed(rq.start_y);
      x1 = $signed(rq.end_x);
      y1 = $signed(rq.end_y);
      if (rq.req_kind != REQ_RAY) begin
         if (in_map(x0, y0))
            rs.cell_value = occ_map[y0 * MAX_W + x0];
         else
            rs.outside_grid = 1'b1;
         return rs;
      end
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = (y1 > y0) ? y1 - y0 : y0 - y1;
      sx = (x0 < x1) ? 1 : -1;
      sy = (y0 < y1) ? 1 : -1;
      err = dx - dy;
      x = x0;
      y = y0;
      changed = 0;
      while (!(x == x1 && y == y1)) begin
         e2 = 2 * err;
         changed += bump_cell(x, y, free_step_q);
         if (e2 > -dy) begin
            err -= dy;
            x += sx;
         end
         if (e2 < dx) begin
            err += dx;
            y += sy;
         end
      end
      if (rq.mark_hit) begin
         landed = bump_cell(x1, y1, occ_step_q);
         changed += landed;
         rs.hit_applied = landed;
      end
      rs.cells_changed = CNT_W'(changed);
      return rs;
   endfunction

   function automatic int near_span(int span);
      return int'($urandom_range(span + 3)) - 2;
   endfunction

   // mostly rays and reads around the grid in use, a few with any coordinates
   function automatic ray_req_type random_request();
      ray_req_type rq;
      logic [63:0] noise;
      int          w, h, reach, x0, y0;
      w = cols_in_use();
      h = rows_in_use();
      reach = ((w > h) ? w : h) + 8;
      if (reach > 48)
         reach = 48;
      if (w >= 256 && $urandom_range(9) == 0)
         reach = 700;
      noise = {$urandom, $urandom};
      rq = noise[$bits(ray_req_type)-1:0];
      if ($urandom_range(99) < 5)
         return rq;
      x0 = near_span(w);
      y0 = near_span(h);
      rq.start_x = COORD_W'(x0);
      rq.start_y = COORD_W'(y0);
      if ($urandom_range(99) < 30) begin
         rq.req_kind = REQ_READ;
      end else begin
         rq.req_kind = REQ_RAY;
         rq.end_x = COORD_W'(x0 + int'($urandom_range(2 * reach)) - reach);
         rq.end_y = COORD_W'(y0 + int'($urandom_range(2 * reach)) - reach);
      end
      return rq;
   endfunction

   task automatic queue_item(ray_req_type rq);
      int dx, dy;
      dx = $signed(rq.end_x) - $signed(rq.start_x);
      dy = $signed(rq.end_y) - $signed(rq.start_y);
      if (dx < 0)
         dx = -dx;
      if (dy < 0)
         dy = -dy;
      if (rq.req_kind == REQ_RAY)
         work_budget += ((dx > dy) ? dx : dy) + 4 + 100;
      else
         work_budget += 3 + 100;
      pending_requests.insert(pending_requests.size(), rq);
   endtask

   task automatic queue_ray(int x0, int y0, int x1, int y1, bit hit);
      ray_req_type rq;
      rq.req_kind = REQ_RAY;
      rq.start_x  = COORD_W'(x0);
      rq.start_y  = COORD_W'(y0);
      rq.end_x    = COORD_W'(x1);
      rq.end_y    = COORD_W'(y1);
      rq.mark_hit = hit;
      queue_item(rq);
   endtask

   task automatic queue_read(int x, int y);
      ray_req_type rq;
      rq = '0;
      rq.req_kind = REQ_READ;
      rq.start_x  = COORD_W'(x);
      rq.start_y  = COORD_W'(y);
      queue_item(rq);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      work_budget += 64;
      case (idx)
         REG_FREE_STEP:  free_step_q = $signed(CELL_W'(value));
         REG_OCC_STEP:   occ_step_q  = value & ((1 << STEP_W) - 1);
         REG_CLAMP_LOW:  clamp_lo_q  = $signed(CELL_W'(value));
         REG_CLAMP_HIGH: clamp_hi_q  = value & ((1 << STEP_W) - 1);
         REG_MAP_WIDTH:  width_q     = value & ((1 << SIZE_W) - 1);
         REG_MAP_HEIGHT: height_q    = value & ((1 << SIZE_W) - 1);
         default: ;
      endcase
   endtask

   task automatic set_map_config(int fs, int os, int cl, int ch, int w, int h);
      write_reg(REG_FREE_STEP, fs);
      write_reg(REG_OCC_STEP, os);
      write_reg(REG_CLAMP_LOW, cl);
      write_reg(REG_CLAMP_HIGH, ch);
      write_reg(REG_MAP_WIDTH, w);
      write_reg(REG_MAP_HEIGHT, h);
   endtask

   // queues random traffic and waits until every transaction has come back
   task automatic run_phase(int send_idle, int recv_stall, int count);
      send_idle_pct  = send_idle;
      recv_stall_pct = recv_stall;
      settings_run++;
      repeat (count) queue_item(random_request());
      while (pending_requests.size() != 0 || req_tvalid || due_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic compare_field(string field, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (got !== want) begin
         if (fail_count < SHOW_LIMIT)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         fail_count++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // driver: offers the next request once the previous one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted = update_grid(req_on_bus);
            due_results.insert(due_results.size(), predicted);
            if (req_on_bus.req_kind == REQ_RAY) begin
               rays_sent++;
               cells_updated += predicted.cells_changed;
               hits_landed += predicted.hit_applied;
            end else begin
               reads_sent++;
               reads_outside += predicted.outside_grid;
            end
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_on_bus = pending_requests.pop_front();
               req_tdata  <= {7'b0, req_on_bus.mark_hit, req_on_bus.end_y, req_on_bus.end_x,
                              req_on_bus.start_y, req_on_bus.start_x};
               req_tuser  <= req_on_bus.req_kind;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, armed once
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_arm && !hold_spent) begin
         hold_left  <= HOLD_CYCLES;
         hold_spent <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: each response transaction against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         observed.cell_value    = rsp_tdata[11:0];
         observed.cells_changed = rsp_tdata[24:12];
         observed.hit_applied   = rsp_tdata[25];
         observed.outside_grid  = rsp_tdata[26];
         if (due_results.size() == 0) begin
            $display("%0t: response with nothing outstanding, expected none, actual %h",
                     $time, rsp_tdata);
            fail_count++;
         end else begin
            wanted = due_results.pop_front();
            compare_field("cell_value", wanted.cell_value, observed.cell_value);
            compare_field("cells_changed", wanted.cells_changed, observed.cells_changed);
            compare_field("hit_applied", wanted.hit_applied, observed.hit_applied);
            compare_field("outside_grid", wanted.outside_grid, observed.outside_grid);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 4 * (MAP_CELLS + work_budget) + 20000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      foreach (occ_map[i])
         occ_map[i] = '0;
      free_step_q = $signed(FREE_STEP_RST);
      occ_step_q  = OCC_STEP_RST;
      clamp_lo_q  = $signed(CLAMP_LOW_RST);
      clamp_hi_q  = CLAMP_HIGH_RST;
      width_q     = MAP_SIZE_RST;
      height_q    = MAP_SIZE_RST;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: edges, reads outside, degenerate and extreme rays
      queue_read(0, 0);
      queue_read(-1, 0);
      queue_read(400, 5);
      queue_read(5, 400);
      queue_ray(5, 5, 5, 5, 1'b1);
      queue_ray(6, 6, 6, 6, 1'b0);
      queue_ray(0, 10, 20, 10, 1'b1);
      queue_read(3, 10);
      queue_read(20, 10);
      queue_ray(30, 30, 10, 25, 1'b1);
      queue_ray(40, 10, 43, 60, 1'b0);
      queue_ray(-5, 3, 6, 3, 1'b1);
      queue_ray(396, 1, 405, 1, 1'b1);
      queue_ray(-2048, -2048, 2047, 2047, 1'b0);
      queue_ray(2047, -2048, -2048, 2047, 1'b1);
      queue_read(399, 399);
      queue_ray(399, 0, 0, 399, 1'b1);
      queue_read(200, 200);
      queue_read(-2048, 2047);
      queue_ray(-2048, 0, -2048, 0, 1'b1);
      run_phase(0, 0, 40);

      // big steps on a small grid to drive cells into both clamps
      set_map_config(-1280, 1280, -2048, 2047, 16, 12);
      queue_ray(3, 3, 3, 3, 1'b1);
      queue_ray(3, 3, 3, 3, 1'b1);
      run_phase(IDLE_HEAVY, 0, 65);

      // zero steps and clamps on a single cell
      set_map_config(0, 0, 0, 0, 1, 1);
      queue_ray(0, 0, 0, 0, 1'b1);
      queue_read(0, 0);
      run_phase(0, IDLE_HEAVY, 45);

      // zero width leaves nothing inside; spare indexes must be ignored
      write_reg(REG_MAP_WIDTH, 0);
      write_reg(REG_MAP_HEIGHT, 5);
      write_reg(REG_SPARE_A, $urandom_range(4095));
      write_reg(REG_SPARE_B, $urandom_range(4095));
      queue_read(0, 0);
      queue_ray(0, 0, 3, 3, 1'b1);
      run_phase(IDLE_BOTH, IDLE_BOTH, 25);

      // sizes above the maximum fall back to the full grid
      set_map_config(-1, 1, -2048, 2047, 1023, 600);
      queue_ray(511, 511, 0, 511, 1'b1);
      queue_ray(0, 0, 511, 511, 1'b1);
      queue_read(511, 511);
      queue_read(512, 0);
      run_phase(0, 0, 70);

      // low clamp above high clamp, grid shrunk, receiver holds off
      set_map_config(-int'($urandom_range(1280)), $urandom_range(1280), 300, 100, 8, 8);
      queue_ray(2, 2, 2, 2, 1'b1);
      queue_ray(0, 0, 5, 5, 1'b0);
      hold_arm = 1'b1;
      run_phase(0, 0, 55);

      // grid grows again, hidden cells come back
      set_map_config(-102, 218, -1280, 1280, 512, 512);
      queue_read(20, 10);
      queue_read(399, 0);
      queue_read(200, 200);
      run_phase(IDLE_BOTH, IDLE_BOTH, 65);

      set_map_config($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                     $urandom_range(4095), $urandom_range(4095), $urandom_range(4095));
      run_phase(IDLE_HEAVY, 0, 60);

      set_map_config($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                     $urandom_range(4095), $urandom_range(4095), $urandom_range(4095));
      run_phase(0, IDLE_HEAVY, 60);

      set_map_config(-int'($urandom_range(1280)), $urandom_range(1280),
                     -int'($urandom_range(2048)), $urandom_range(2047),
                     $urandom_range(1, 32), $urandom_range(1, 32));
      run_phase(IDLE_BOTH, IDLE_BOTH, 55);

      repeat (16) @(posedge clock);
      $display("covered %0d ray updates and %0d cell reads over %0d register settings",
               rays_sent, reads_sent, settings_run);
      $display("%0d cells updated, %0d hits landed, %0d reads outside the grid",
               cells_updated, hits_landed, reads_outside);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
